### rtl/sisc_pkg.sv
// ----------------------------------------------------------------------------
// sisc_pkg: subset interval cover search shared definitions
// Sizes, command and status codes, table and stack entry layouts, the
// controller/datapath command and status groups, and bit-set helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sisc_pkg;

   localparam int MAX_DIM       = 64;
   localparam int MAX_INTERVALS = 256;
   localparam int STACK_DEPTH   = 65;

   localparam int DIM_W   = 7;
   localparam int IDX_W   = $clog2(MAX_INTERVALS);
   localparam int TOTAL_W = $clog2(MAX_INTERVALS + 1);
   localparam int SLOT_W  = $clog2(2 * STACK_DEPTH);
   localparam int TOP_W   = $clog2(STACK_DEPTH + 1);
   localparam int TRIG_W  = 6;

   localparam logic [2:0] CMD_ADD       = 3'd0;
   localparam logic [2:0] CMD_COVER_SET = 3'd1;
   localparam logic [2:0] CMD_COVER_IVL = 3'd2;
   localparam logic [2:0] CMD_START     = 3'd3;
   localparam logic [2:0] CMD_TAKE      = 3'd4;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_INVALID     = 3'd1;
   localparam logic [2:0] ST_SIZE_BIG    = 3'd2;
   localparam logic [2:0] ST_NOT_STARTED = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL  = 3'd4;

   typedef enum logic [1:0] {
      SCAN_SET,
      SCAN_IVL,
      SCAN_PRUNE,
      SCAN_FILL
   } scan_mode_type;

   typedef struct packed {
      logic [63:0]       lower;
      logic [63:0]       upper;
      logic [DIM_W-1:0]  lower_count;
      logic [DIM_W-1:0]  upper_count;
      logic [TRIG_W-1:0] trigger;
   } tbl_entry_type;

   typedef struct packed {
      logic [63:0]        value;
      logic [DIM_W-1:0]   length;
      logic [DIM_W-1:0]   chosen;
      logic [TOTAL_W-1:0] known_total;
   } stk_entry_type;

   typedef struct packed {
      logic          accept;
      logic          add_write;
      logic          add_universal;
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          scan_next;
      logic          tbl_rd;
      logic          stk_pop;
      logic          stk_load;
      logic          push0;
      logic          push1;
      logic          fill_init;
      logic          fill_step;
      logic          fill_next;
      logic          start_stream;
      logic          mark_exhausted;
      logic          set_res;
      logic [2:0]    res_status;
      logic          res_answer;
      logic          res_found;
      logic          emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [2:0]    cmd;
      logic          invalid_ivl;
      logic          all_covered;
      logic          universal;
      logic          table_full;
      logic          card_gt_dim;
      logic          stream_same;
      logic          started;
      logic          exhausted;
      logic          top_zero;
      logic          skip;
      logic          scan_end;
      logic          hit;
      scan_mode_type scan_mode;
      logic          fill_case;
      logic          fill_done;
      logic          out_free;
   } ctrl_stat_type;

   function automatic logic [DIM_W-1:0] pop64(input logic [63:0] v);
      logic [DIM_W-1:0] sum;
      logic [3:0]       cnt;
      sum = '0;
      for (int j = 0; j < 8; j++) begin
         cnt = '0;
         for (int t = 0; t < 8; t++) begin
            cnt = cnt + {3'b000, v[8*j+t]};
         end
         sum = sum + {3'b000, cnt};
      end
      return sum;
   endfunction

   function automatic logic [TRIG_W-1:0] high_bit64(input logic [63:0] c);
      logic [2:0] bj;
      logic [2:0] bt;
      logic [7:0] byte_v;
      bj = '0;
      bt = '0;
      for (int j = 0; j < 8; j++) begin
         if (c[8*j +: 8] != 8'd0) begin
            bj = 3'(j);
         end
      end
      byte_v = c[{bj, 3'b000} +: 8];
      for (int t = 0; t < 8; t++) begin
         if (byte_v[t]) begin
            bt = 3'(t);
         end
      end
      return {bj, bt};
   endfunction

   function automatic logic [63:0] dim_mask(input logic [DIM_W-1:0] d);
      if (d >= DIM_W'(MAX_DIM)) begin
         return '1;
      end
      return (64'd1 << d[5:0]) - 64'd1;
   endfunction

   function automatic logic inside_of(input logic [63:0] a, input logic [63:0] b);
      return (a & ~b) == 64'd0;
   endfunction

endpackage

`default_nettype wire

### rtl/sisc_req_if.sv
// ----------------------------------------------------------------------------
// sisc_req_if: request channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sisc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [63:0] lower_mask;
   logic [63:0] upper_mask;
   logic [63:0] candidate_mask;
   logic        stream_sel;
   logic [6:0]  cardinality;

   modport source (output valid, cmd, lower_mask, upper_mask, candidate_mask,
                   stream_sel, cardinality, input ready);
   modport sink (input valid, cmd, lower_mask, upper_mask, candidate_mask,
                 stream_sel, cardinality, output ready);
endinterface

`default_nettype wire

### rtl/sisc_rsp_if.sv
// ----------------------------------------------------------------------------
// sisc_rsp_if: response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sisc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        answer;
   logic [63:0] support_mask;

   modport source (output valid, status, answer, support_mask, input ready);
   modport sink (input valid, status, answer, support_mask, output ready);
endinterface

`default_nettype wire

### rtl/sisc_dpath.sv
// ----------------------------------------------------------------------------
// sisc_dpath: subset interval cover search datapath
// Interval table and prefix stack memories, stream state, scan index,
// enumeration working registers and the response output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sisc_dpath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [6:0]            csr_wr_data,
   input  wire logic [2:0]            req_cmd,
   input  wire logic [63:0]           req_lower_mask,
   input  wire logic [63:0]           req_upper_mask,
   input  wire logic [63:0]           req_candidate_mask,
   input  wire logic                  req_stream_sel,
   input  wire logic [6:0]            req_cardinality,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic                       rsp_answer,
   output logic [63:0]                rsp_support_mask,
   input  wire sisc_pkg::ctrl_cmd_type ctl,
   output sisc_pkg::ctrl_stat_type    stat
);

   localparam int DW = sisc_pkg::DIM_W;
   localparam int TW = sisc_pkg::TOTAL_W;
   localparam int SW = sisc_pkg::SLOT_W;
   localparam int PW = sisc_pkg::TOP_W;

   logic [DW-1:0] dim_ff, dim_in;
   logic [63:0]   dm;
   logic [2:0]    cmd_ff, cmd_in;
   logic [63:0]   lo_ff, lo_in, up_ff, up_in, cand_ff, cand_in;
   logic          sel_ff, sel_in;
   logic [DW-1:0] card_ff, card_in;
   logic [DW-1:0] lc_ff, lc_in, uc_ff, uc_in;
   logic [sisc_pkg::TRIG_W-1:0] trig_ff, trig_in;
   logic [TW-1:0] total_ff, total_in;
   logic          all_cov_ff, all_cov_in;
   logic [1:0]    started_ff, started_in, exhausted_ff, exhausted_in;
   logic [DW-1:0] size_ff [2];
   logic [DW-1:0] size_in [2];
   logic [PW-1:0] top_ff [2];
   logic [PW-1:0] top_in [2];
   logic [TW-1:0] idx_ff, idx_in;
   sisc_pkg::scan_mode_type mode_ff, mode_in;
   logic [63:0]   v_ff, v_in;
   logic [DW-1:0] len_ff, len_in, chosen_ff, chosen_in, k_ff, k_in;
   logic [TW-1:0] known_ff, known_in;
   logic [2:0]    res_status_ff, res_status_in;
   logic          res_answer_ff, res_answer_in;
   logic [63:0]   res_mask_ff, res_mask_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_answer_ff, rsp_answer_in;
   logic [63:0]   rsp_mask_ff, rsp_mask_in;

   sisc_pkg::tbl_entry_type tbl_mem [sisc_pkg::MAX_INTERVALS];
   sisc_pkg::tbl_entry_type tbl_rd_ff, tbl_wdata;
   logic                    tbl_we;
   sisc_pkg::stk_entry_type stk_mem [2 * sisc_pkg::STACK_DEPTH];
   sisc_pkg::stk_entry_type stk_rd_ff, stk_wdata;
   logic                    stk_we, stk_re;
   logic [SW-1:0]           stk_waddr, stk_raddr;

   logic [DW-1:0] cur_size, needed, remaining, len_m1;
   logic [PW-1:0] cur_top;
   logic [DW-1:0] dclamp;
   logic          fits, in_v;

   function automatic logic [SW-1:0] slot_of(input logic s, input logic [PW-1:0] t);
      return (s ? SW'(sisc_pkg::STACK_DEPTH) : SW'(0)) + SW'(t);
   endfunction

   assign dm        = sisc_pkg::dim_mask(dim_ff);
   assign cur_size  = size_ff[sel_ff];
   assign cur_top   = top_ff[sel_ff];
   assign needed    = cur_size - chosen_ff;
   assign remaining = dim_ff - len_ff;
   assign len_m1    = len_ff - DW'(1);

   assign fits = (tbl_rd_ff.lower_count <= cur_size) && (tbl_rd_ff.upper_count >= cur_size);
   assign in_v = sisc_pkg::inside_of(tbl_rd_ff.lower, v_ff)
              && sisc_pkg::inside_of(v_ff, tbl_rd_ff.upper);

   always_comb begin
      stat.cmd         = cmd_ff;
      stat.invalid_ivl = !sisc_pkg::inside_of(lo_ff, up_ff);
      stat.all_covered = all_cov_ff;
      stat.universal   = (lc_ff == '0) && (uc_ff == dim_ff);
      stat.table_full  = total_ff >= TW'(sisc_pkg::MAX_INTERVALS);
      stat.card_gt_dim = card_ff > dim_ff;
      stat.stream_same = started_ff[sel_ff] && (cur_size == card_ff);
      stat.started     = started_ff[sel_ff];
      stat.exhausted   = exhausted_ff[sel_ff];
      stat.top_zero    = cur_top == '0;
      stat.skip        = (stk_rd_ff.length > dim_ff) || (stk_rd_ff.chosen > cur_size)
                      || ((cur_size - stk_rd_ff.chosen) > (dim_ff - stk_rd_ff.length));
      stat.scan_end    = (idx_ff >= total_ff)
                      || ((mode_ff == sisc_pkg::SCAN_PRUNE) && (len_ff == '0));
      stat.scan_mode   = mode_ff;
      stat.fill_case   = (needed == '0) || (needed == remaining);
      stat.fill_done   = k_ff >= dim_ff;
      stat.out_free    = !rsp_valid_ff || rsp_ready;
      case (mode_ff)
         sisc_pkg::SCAN_SET: begin
            stat.hit = sisc_pkg::inside_of(tbl_rd_ff.lower, cand_ff)
                    && sisc_pkg::inside_of(cand_ff, tbl_rd_ff.upper);
         end
         sisc_pkg::SCAN_IVL: begin
            stat.hit = sisc_pkg::inside_of(tbl_rd_ff.lower, lo_ff)
                    && sisc_pkg::inside_of(up_ff, tbl_rd_ff.upper);
         end
         sisc_pkg::SCAN_PRUNE: begin
            stat.hit = fits && in_v
                    && (({1'b0, tbl_rd_ff.trigger} == len_m1)
                     || ((idx_ff >= known_ff) && ({1'b0, tbl_rd_ff.trigger} < len_m1)));
         end
         default: begin
            stat.hit = fits && in_v && ({1'b0, tbl_rd_ff.trigger} == k_ff);
         end
      endcase
   end

   always_comb begin
      dclamp = csr_wr_data;
      if (csr_wr_data == '0) begin
         dclamp = DW'(1);
      end else if (csr_wr_data > DW'(sisc_pkg::MAX_DIM)) begin
         dclamp = DW'(sisc_pkg::MAX_DIM);
      end
   end

   always_comb begin
      dim_in        = dim_ff;
      cmd_in        = cmd_ff;
      lo_in         = lo_ff;
      up_in         = up_ff;
      cand_in       = cand_ff;
      sel_in        = sel_ff;
      card_in       = card_ff;
      lc_in         = sisc_pkg::pop64(lo_ff);
      uc_in         = sisc_pkg::pop64(up_ff);
      trig_in       = sisc_pkg::high_bit64((lo_ff | ~up_ff) & dm);
      total_in      = total_ff;
      all_cov_in    = all_cov_ff;
      started_in    = started_ff;
      exhausted_in  = exhausted_ff;
      size_in       = size_ff;
      top_in        = top_ff;
      idx_in        = idx_ff;
      mode_in       = mode_ff;
      v_in          = v_ff;
      len_in        = len_ff;
      chosen_in     = chosen_ff;
      known_in      = known_ff;
      k_in          = k_ff;
      res_status_in = res_status_ff;
      res_answer_in = res_answer_ff;
      res_mask_in   = res_mask_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_answer_in = rsp_answer_ff;
      rsp_mask_in   = rsp_mask_ff;
      tbl_we        = 1'b0;
      tbl_wdata     = {lo_ff, up_ff, lc_ff, uc_ff, trig_ff};
      stk_we        = 1'b0;
      stk_waddr     = slot_of(sel_ff, cur_top);
      stk_wdata     = {v_ff, len_ff + DW'(1), chosen_ff, total_ff};
      stk_re        = 1'b0;
      stk_raddr     = slot_of(sel_ff, cur_top - PW'(1));

      if (ctl.accept) begin
         cmd_in  = req_cmd;
         lo_in   = req_lower_mask & dm;
         up_in   = req_upper_mask & dm;
         cand_in = req_candidate_mask & dm;
         sel_in  = req_stream_sel;
         card_in = req_cardinality;
      end
      if (ctl.add_write) begin
         tbl_we   = 1'b1;
         total_in = total_ff + TW'(1);
      end
      if (ctl.add_universal) begin
         total_in     = '0;
         all_cov_in   = 1'b1;
         top_in[0]    = '0;
         top_in[1]    = '0;
         exhausted_in = 2'b11;
      end
      if (ctl.scan_start) begin
         idx_in  = '0;
         mode_in = ctl.scan_mode;
      end
      if (ctl.scan_next) begin
         idx_in = idx_ff + TW'(1);
      end
      if (ctl.stk_pop) begin
         stk_re          = 1'b1;
         top_in[sel_ff]  = cur_top - PW'(1);
      end
      if (ctl.stk_load) begin
         v_in      = stk_rd_ff.value;
         len_in    = stk_rd_ff.length;
         chosen_in = stk_rd_ff.chosen;
         known_in  = stk_rd_ff.known_total;
      end
      if (ctl.push0 && (cur_top < PW'(sisc_pkg::STACK_DEPTH))) begin
         stk_we         = 1'b1;
         top_in[sel_ff] = cur_top + PW'(1);
      end
      if (ctl.push1) begin
         stk_wdata = {v_ff | (64'd1 << len_ff[5:0]), len_ff + DW'(1),
                      chosen_ff + DW'(1), total_ff};
         if (cur_top < PW'(sisc_pkg::STACK_DEPTH)) begin
            stk_we         = 1'b1;
            top_in[sel_ff] = cur_top + PW'(1);
         end
      end
      if (ctl.fill_init) begin
         k_in = len_ff;
      end
      if (ctl.fill_step && (needed != '0)) begin
         v_in = v_ff | (64'd1 << k_ff[5:0]);
      end
      if (ctl.fill_next) begin
         k_in = k_ff + DW'(1);
      end
      if (ctl.start_stream) begin
         started_in[sel_ff]   = 1'b1;
         size_in[sel_ff]      = card_ff;
         exhausted_in[sel_ff] = all_cov_ff;
         top_in[sel_ff]       = all_cov_ff ? PW'(0) : PW'(1);
         stk_we               = !all_cov_ff;
         stk_waddr            = slot_of(sel_ff, '0);
         stk_wdata            = {64'd0, DW'(0), DW'(0), total_ff};
      end
      if (ctl.mark_exhausted) begin
         exhausted_in[sel_ff] = 1'b1;
      end
      if (ctl.set_res) begin
         res_status_in = ctl.res_status;
         res_answer_in = ctl.res_answer;
         res_mask_in   = ctl.res_found ? (v_ff & dm) : 64'd0;
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_answer_in = res_answer_ff;
         rsp_mask_in   = res_mask_ff;
      end
      if (csr_wr_en) begin
         dim_in       = dclamp;
         total_in     = '0;
         all_cov_in   = 1'b0;
         started_in   = '0;
         exhausted_in = '0;
         size_in[0]   = '0;
         size_in[1]   = '0;
         top_in[0]    = '0;
         top_in[1]    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff       <= DW'(sisc_pkg::MAX_DIM);
         total_ff     <= '0;
         all_cov_ff   <= 1'b0;
         started_ff   <= '0;
         exhausted_ff <= '0;
         size_ff[0]   <= '0;
         size_ff[1]   <= '0;
         top_ff[0]    <= '0;
         top_ff[1]    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dim_ff       <= dim_in;
         total_ff     <= total_in;
         all_cov_ff   <= all_cov_in;
         started_ff   <= started_in;
         exhausted_ff <= exhausted_in;
         size_ff      <= size_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      lo_ff         <= lo_in;
      up_ff         <= up_in;
      cand_ff       <= cand_in;
      sel_ff        <= sel_in;
      card_ff       <= card_in;
      lc_ff         <= lc_in;
      uc_ff         <= uc_in;
      trig_ff       <= trig_in;
      idx_ff        <= idx_in;
      mode_ff       <= mode_in;
      v_ff          <= v_in;
      len_ff        <= len_in;
      chosen_ff     <= chosen_in;
      known_ff      <= known_in;
      k_ff          <= k_in;
      res_status_ff <= res_status_in;
      res_answer_ff <= res_answer_in;
      res_mask_ff   <= res_mask_in;
      rsp_status_ff <= rsp_status_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_mask_ff   <= rsp_mask_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[total_ff[sisc_pkg::IDX_W-1:0]] <= tbl_wdata;
      end
      if (ctl.tbl_rd) begin
         tbl_rd_ff <= tbl_mem[idx_ff[sisc_pkg::IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_answer       = rsp_answer_ff;
   assign rsp_support_mask = rsp_mask_ff;

endmodule

`default_nettype wire

### rtl/sisc_ctrl.sv
// ----------------------------------------------------------------------------
// sisc_ctrl: subset interval cover search controller
// Sequences command decode, table scans, stack pops and pushes, the final
// fill walk and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sisc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire sisc_pkg::ctrl_stat_type stat,
   output sisc_pkg::ctrl_cmd_type      ctl
);

   typedef enum logic [11:0] {
      S_IDLE    = 12'b0000_0000_0001,
      S_DECODE  = 12'b0000_0000_0010,
      S_ADD     = 12'b0000_0000_0100,
      S_SCAN_RD = 12'b0000_0000_1000,
      S_SCAN_EV = 12'b0000_0001_0000,
      S_POP     = 12'b0000_0010_0000,
      S_CHECK   = 12'b0000_0100_0000,
      S_DECIDE  = 12'b0000_1000_0000,
      S_PUSH0   = 12'b0001_0000_0000,
      S_PUSH1   = 12'b0010_0000_0000,
      S_FILL    = 12'b0100_0000_0000,
      S_RESP    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            ctl.set_res    = 1'b1;
            ctl.res_status = sisc_pkg::ST_OK;
            state_in       = S_RESP;
            case (stat.cmd)
               sisc_pkg::CMD_ADD: begin
                  if (stat.invalid_ivl) begin
                     ctl.res_status = sisc_pkg::ST_INVALID;
                  end else if (!stat.all_covered) begin
                     ctl.set_res = 1'b0;
                     state_in    = S_ADD;
                  end
               end
               sisc_pkg::CMD_COVER_SET: begin
                  if (stat.all_covered) begin
                     ctl.res_answer = 1'b1;
                  end else begin
                     ctl.set_res    = 1'b0;
                     ctl.scan_start = 1'b1;
                     ctl.scan_mode  = sisc_pkg::SCAN_SET;
                     state_in       = S_SCAN_RD;
                  end
               end
               sisc_pkg::CMD_COVER_IVL: begin
                  if (stat.invalid_ivl) begin
                     ctl.res_status = sisc_pkg::ST_INVALID;
                  end else if (stat.all_covered) begin
                     ctl.res_answer = 1'b1;
                  end else begin
                     ctl.set_res    = 1'b0;
                     ctl.scan_start = 1'b1;
                     ctl.scan_mode  = sisc_pkg::SCAN_IVL;
                     state_in       = S_SCAN_RD;
                  end
               end
               sisc_pkg::CMD_START: begin
                  if (stat.card_gt_dim) begin
                     ctl.res_status = sisc_pkg::ST_SIZE_BIG;
                  end else if (!stat.stream_same) begin
                     ctl.start_stream = 1'b1;
                  end
               end
               sisc_pkg::CMD_TAKE: begin
                  if (!stat.started) begin
                     ctl.res_status = sisc_pkg::ST_NOT_STARTED;
                  end else if (!stat.exhausted && !stat.all_covered) begin
                     ctl.set_res = 1'b0;
                     state_in    = S_POP;
                  end
               end
               default: begin
                  ctl.res_status = sisc_pkg::ST_OK;
               end
            endcase
         end
         S_ADD: begin
            ctl.set_res    = 1'b1;
            ctl.res_status = sisc_pkg::ST_OK;
            state_in       = S_RESP;
            if (stat.universal) begin
               ctl.add_universal = 1'b1;
            end else if (stat.table_full) begin
               ctl.res_status = sisc_pkg::ST_TABLE_FULL;
            end else begin
               ctl.add_write = 1'b1;
            end
         end
         S_SCAN_RD: begin
            if (stat.scan_end) begin
               case (stat.scan_mode)
                  sisc_pkg::SCAN_PRUNE: begin
                     state_in = S_DECIDE;
                  end
                  sisc_pkg::SCAN_FILL: begin
                     ctl.fill_next = 1'b1;
                     state_in      = S_FILL;
                  end
                  default: begin
                     ctl.set_res    = 1'b1;
                     ctl.res_status = sisc_pkg::ST_OK;
                     state_in       = S_RESP;
                  end
               endcase
            end else begin
               ctl.tbl_rd = 1'b1;
               state_in   = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            if (stat.hit) begin
               if ((stat.scan_mode == sisc_pkg::SCAN_PRUNE)
                   || (stat.scan_mode == sisc_pkg::SCAN_FILL)) begin
                  state_in = S_POP;
               end else begin
                  ctl.set_res    = 1'b1;
                  ctl.res_status = sisc_pkg::ST_OK;
                  ctl.res_answer = 1'b1;
                  state_in       = S_RESP;
               end
            end else begin
               ctl.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_POP: begin
            if (stat.top_zero) begin
               ctl.mark_exhausted = 1'b1;
               ctl.set_res        = 1'b1;
               ctl.res_status     = sisc_pkg::ST_OK;
               state_in           = S_RESP;
            end else begin
               ctl.stk_pop = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.skip) begin
               state_in = S_POP;
            end else begin
               ctl.stk_load   = 1'b1;
               ctl.scan_start = 1'b1;
               ctl.scan_mode  = sisc_pkg::SCAN_PRUNE;
               state_in       = S_SCAN_RD;
            end
         end
         S_DECIDE: begin
            if (stat.fill_case) begin
               ctl.fill_init = 1'b1;
               state_in      = S_FILL;
            end else begin
               state_in = S_PUSH0;
            end
         end
         S_PUSH0: begin
            ctl.push0 = 1'b1;
            state_in  = S_PUSH1;
         end
         S_PUSH1: begin
            ctl.push1 = 1'b1;
            state_in  = S_POP;
         end
         S_FILL: begin
            if (stat.fill_done) begin
               ctl.set_res    = 1'b1;
               ctl.res_status = sisc_pkg::ST_OK;
               ctl.res_answer = 1'b1;
               ctl.res_found  = 1'b1;
               state_in       = S_RESP;
            end else begin
               ctl.fill_step  = 1'b1;
               ctl.scan_start = 1'b1;
               ctl.scan_mode  = sisc_pkg::SCAN_FILL;
               state_in       = S_SCAN_RD;
            end
         end
         S_RESP: begin
            if (stat.out_free) begin
               ctl.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/subset_interval_cover_search_unit.sv
// Queries scan the stored intervals and stop at the first hit. Take next pops
// prefixes, skipping those that cannot reach the size, and scans the table for
// each prefix it keeps and for each coordinate of the final fill walk; every
// scan shares the single table read port. One command in flight at a time.
// Reset: synchronous; clears table count, flags and streams, sets dimension to 64.
// ----------------------------------------------------------------------------
// subset_interval_cover_search_unit: subset interval cover search top level
// Joins the controller and the datapath to the request, response and
// configuration ports.
// ----------------------------------------------------------------------------
`default_nettype none

module subset_interval_cover_search_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_wr_en,
   input  wire logic [6:0] csr_wr_data,
   sisc_req_if.sink   req,
   sisc_rsp_if.source rsp
);

   sisc_pkg::ctrl_cmd_type  ctl;
   sisc_pkg::ctrl_stat_type stat;

   sisc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   sisc_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_cmd            (req.cmd),
      .req_lower_mask     (req.lower_mask),
      .req_upper_mask     (req.upper_mask),
      .req_candidate_mask (req.candidate_mask),
      .req_stream_sel     (req.stream_sel),
      .req_cardinality    (req.cardinality),
      .rsp_ready          (rsp.ready),
      .rsp_valid          (rsp.valid),
      .rsp_status         (rsp.status),
      .rsp_answer         (rsp.answer),
      .rsp_support_mask   (rsp.support_mask),
      .ctl                (ctl),
      .stat               (stat)
   );

endmodule

`default_nettype wire

### rtl/sisc_checker.sv
// ----------------------------------------------------------------------------
// sisc_checker: port-level checks for the cover search unit
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
`default_nettype none

module sisc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic        rsp_answer,
   input wire logic [63:0] rsp_support_mask
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_answer) && $stable(rsp_support_mask))
      else $error("response word changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a command is in progress");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != sisc_pkg::ST_OK) |-> !rsp_answer
         && (rsp_support_mask == 64'd0))
      else $error("error word carries an answer or a mask");

   a_mask_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_support_mask != 64'd0) |-> rsp_answer)
      else $error("mask without answer");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == sisc_pkg::ST_OK) || (rsp_status == sisc_pkg::ST_INVALID)
         || (rsp_status == sisc_pkg::ST_SIZE_BIG) || (rsp_status == sisc_pkg::ST_NOT_STARTED)
         || (rsp_status == sisc_pkg::ST_TABLE_FULL))
      else $error("status code out of range");

endmodule

bind subset_interval_cover_search_unit sisc_checker u_sisc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_answer       (rsp.answer),
   .rsp_support_mask (rsp.support_mask)
);

`default_nettype wire

### dv/subset_interval_cover_search_unit_tb.sv
// ----------------------------------------------------------------------------
// subset_interval_cover_search_unit_tb: self-checking regression bench
// Drives command words over the request channel and predicts each result word.
// The prediction comes from a behavioral copy of the interval table and of the
// two enumeration streams. Runs directed checks, a table-full pass, and random
// phases over several dimensions, with random idling and a long response stall.
// ----------------------------------------------------------------------------
`default_nettype none

module subset_interval_cover_search_unit_tb;

   localparam logic [2:0] CMD_SPARE_LO = sisc_pkg::CMD_TAKE + 3'd1;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   typedef struct {
      logic [2:0]  status;
      logic        answer;
      logic [63:0] support;
   } cover_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [6:0] csr_wr_data = '0;

   sisc_req_if req_ch ();
   sisc_rsp_if rsp_ch ();

   subset_interval_cover_search_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch)
   );

   always #6 clock = ~clock;

   // cover model state
   logic [63:0] ivl_lo [sisc_pkg::MAX_INTERVALS];
   logic [63:0] ivl_up [sisc_pkg::MAX_INTERVALS];
   int          ivl_lc [sisc_pkg::MAX_INTERVALS];
   int          ivl_uc [sisc_pkg::MAX_INTERVALS];
   int          ivl_trig [sisc_pkg::MAX_INTERVALS];
   int          ivl_count;
   bit          universe_hit;
   bit          strm_on [2];
   bit          strm_done [2];
   int          strm_card [2];
   logic [63:0] pfx_val [2*sisc_pkg::STACK_DEPTH];
   int          pfx_len [2*sisc_pkg::STACK_DEPTH];
   int          pfx_ch [2*sisc_pkg::STACK_DEPTH];
   int          pfx_known [2*sisc_pkg::STACK_DEPTH];
   int          pfx_top [2];
   int          dim;

   cover_result_type pending_results [$];
   int errors = 0;
   bit idle_on = 1'b1;
   int hold_len = 0;
   int hold_seq = 0;
   int hold_seen = 0;
   int hold_cycles = 0;

   function automatic logic [63:0] coord_mask();
      if (dim >= 64) return '1;
      return (64'd1 << dim) - 64'd1;
   endfunction

   function automatic bit subset_of(logic [63:0] a, logic [63:0] b);
      return (a & ~b) == 64'd0;
   endfunction

   function automatic void drop_stream(int s);
      pfx_top[s] = 0;
      strm_on[s] = 0;
      strm_done[s] = 0;
      strm_card[s] = 0;
   endfunction

   function automatic void clear_cover();
      ivl_count = 0;
      universe_hit = 0;
      drop_stream(0);
      drop_stream(1);
   endfunction

   function automatic void push_prefix(int s, logic [63:0] v, int len, int chosen);
      int slot;
      if (pfx_top[s] >= sisc_pkg::STACK_DEPTH) return;
      slot = s * sisc_pkg::STACK_DEPTH + pfx_top[s];
      pfx_val[slot] = v;
      pfx_len[slot] = len;
      pfx_ch[slot] = chosen;
      pfx_known[slot] = ivl_count;
      pfx_top[s]++;
   endfunction

   function automatic bit size_fits(int i, int size);
      return ivl_lc[i] <= size && ivl_uc[i] >= size;
   endfunction

   function automatic bit trig_cover(int trig, logic [63:0] v, int size);
      for (int i = 0; i < ivl_count; i++) begin
         if (ivl_trig[i] == trig && size_fits(i, size) &&
             subset_of(ivl_lo[i], v) && subset_of(v, ivl_up[i])) return 1;
      end
      return 0;
   endfunction

   function automatic bit later_cover(int from, int len, logic [63:0] v, int size);
      if (len == 0) return 0;
      for (int i = from; i < ivl_count; i++) begin
         if (ivl_trig[i] < len - 1 && size_fits(i, size) &&
             subset_of(ivl_lo[i], v) && subset_of(v, ivl_up[i])) return 1;
      end
      return 0;
   endfunction

   function automatic bit next_uncovered(int s, output logic [63:0] found);
      int size, slot, len, chosen, known, remaining, needed;
      logic [63:0] v;
      bit covered;
      size = strm_card[s];
      found = '0;
      while (pfx_top[s] > 0) begin
         pfx_top[s]--;
         slot = s * sisc_pkg::STACK_DEPTH + pfx_top[s];
         v = pfx_val[slot];
         len = pfx_len[slot];
         chosen = pfx_ch[slot];
         known = pfx_known[slot];
         if (len > dim) continue;
         remaining = dim - len;
         if (chosen > size || size - chosen > remaining) continue;
         if (later_cover(known, len, v, size)) continue;
         if (len != 0 && trig_cover(len - 1, v, size)) continue;
         needed = size - chosen;
         if (needed == 0 || needed == remaining) begin
            covered = 0;
            for (int k = len; k < dim; k++) begin
               if (needed != 0) v |= 64'd1 << k;
               if (trig_cover(k, v, size)) begin
                  covered = 1;
                  break;
               end
            end
            if (!covered) begin
               found = v;
               return 1;
            end
            continue;
         end
         push_prefix(s, v, len + 1, chosen);
         push_prefix(s, v | (64'd1 << len), len + 1, chosen + 1);
      end
      strm_done[s] = 1;
      return 0;
   endfunction

   function automatic cover_result_type predict_cover(logic [2:0] c, logic [63:0] lo_in,
         logic [63:0] up_in, logic [63:0] cand_in, bit s, logic [6:0] card);
      cover_result_type r;
      logic [63:0] dm, lo, up, cand, f;
      int lc, uc, trig;
      dm = coord_mask();
      lo = lo_in & dm;
      up = up_in & dm;
      cand = cand_in & dm;
      r.status = sisc_pkg::ST_OK;
      r.answer = 0;
      r.support = '0;
      case (c)
         sisc_pkg::CMD_ADD: begin
            if (!subset_of(lo, up)) r.status = sisc_pkg::ST_INVALID;
            else if (!universe_hit) begin
               lc = $countones(lo);
               uc = $countones(up);
               if (lc == 0 && uc == dim) begin
                  ivl_count = 0;
                  universe_hit = 1;
                  pfx_top[0] = 0;
                  pfx_top[1] = 0;
                  strm_done[0] = 1;
                  strm_done[1] = 1;
               end else if (ivl_count >= sisc_pkg::MAX_INTERVALS) begin
                  r.status = sisc_pkg::ST_TABLE_FULL;
               end else begin
                  trig = 0;
                  for (int k = dim; k > 0; k--) begin
                     if (lo[k-1] || !up[k-1]) begin
                        trig = k - 1;
                        break;
                     end
                  end
                  ivl_lo[ivl_count] = lo;
                  ivl_up[ivl_count] = up;
                  ivl_lc[ivl_count] = lc;
                  ivl_uc[ivl_count] = uc;
                  ivl_trig[ivl_count] = trig;
                  ivl_count++;
               end
            end
         end
         sisc_pkg::CMD_COVER_SET: begin
            r.answer = universe_hit;
            for (int i = 0; i < ivl_count && !r.answer; i++)
               if (subset_of(ivl_lo[i], cand) && subset_of(cand, ivl_up[i])) r.answer = 1;
         end
         sisc_pkg::CMD_COVER_IVL: begin
            if (!subset_of(lo, up)) r.status = sisc_pkg::ST_INVALID;
            else begin
               r.answer = universe_hit;
               for (int i = 0; i < ivl_count && !r.answer; i++)
                  if (subset_of(ivl_lo[i], lo) && subset_of(up, ivl_up[i])) r.answer = 1;
            end
         end
         sisc_pkg::CMD_START: begin
            if (card > dim) r.status = sisc_pkg::ST_SIZE_BIG;
            else if (!(strm_on[s] && strm_card[s] == card)) begin
               drop_stream(s);
               strm_on[s] = 1;
               strm_card[s] = card;
               if (universe_hit) strm_done[s] = 1;
               else push_prefix(s, '0, 0, 0);
            end
         end
         sisc_pkg::CMD_TAKE: begin
            if (!strm_on[s]) r.status = sisc_pkg::ST_NOT_STARTED;
            else if (!strm_done[s] && !universe_hit) begin
               if (next_uncovered(s, f)) begin
                  r.answer = 1;
                  r.support = f & dm;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic send_word(logic [2:0] c, logic [63:0] lo, logic [63:0] up,
         logic [63:0] cand, bit s, logic [6:0] card);
      if (idle_on && $urandom_range(99) < 23) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= c;
      req_ch.lower_mask <= lo;
      req_ch.upper_mask <= up;
      req_ch.candidate_mask <= cand;
      req_ch.stream_sel <= s;
      req_ch.cardinality <= card;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.insert(pending_results.size(),
                             predict_cover(c, lo, up, cand, s, card));
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_dimension(logic [6:0] d);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      dim = (d == 0) ? 1 : (d > sisc_pkg::MAX_DIM) ? sisc_pkg::MAX_DIM : d;
      clear_cover();
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // response checker
   always @(posedge clock) begin
      cover_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", rsp_ch.status, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", rsp_ch.status, want.status);
            if (rsp_ch.answer !== want.answer)
               report_mismatch("answer", rsp_ch.answer, want.answer);
            if (rsp_ch.support_mask !== want.support)
               report_mismatch("support_mask", rsp_ch.support_mask, want.support);
         end
      end
   end

   // response ready with random stalls and an optional long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_seq != hold_seen) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles <= hold_len;
         hold_seen <= hold_seq;
      end else if (hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ch.ready <= idle_on ? ($urandom_range(99) >= 23) : 1'b1;
      end
   end

   task automatic test_basic_commands();
      write_dimension(7'd64);
      send_word(sisc_pkg::CMD_TAKE, '0, '0, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_START, '0, '0, '0, 1'b1, 7'd65);
      send_word(sisc_pkg::CMD_ADD, 64'hF0, 64'h0F, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_COVER_IVL, 64'h3, 64'h1, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_ADD, 64'h1, 64'hFFFF_FFFF_FFFF_FFF7, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_ADD, 64'h8000_0000_0000_0000, '1, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_COVER_SET, '0, '0, 64'h5, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_COVER_SET, '0, '0, '1, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_COVER_IVL, 64'h1, 64'h3, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_START, '0, '0, '0, 1'b0, 7'd1);
      send_word(sisc_pkg::CMD_TAKE, '0, '0, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_TAKE, '0, '0, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_START, '0, '0, '0, 1'b0, 7'd1);
      send_word(sisc_pkg::CMD_TAKE, '0, '0, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_START, '0, '0, '0, 1'b1, 7'd64);
      send_word(sisc_pkg::CMD_TAKE, '0, '0, '0, 1'b1, 7'd0);
      send_word(sisc_pkg::CMD_TAKE, '0, '0, '0, 1'b1, 7'd0);
      send_word(sisc_pkg::CMD_START, '0, '0, '0, 1'b1, 7'd0);
      send_word(sisc_pkg::CMD_TAKE, '0, '0, '0, 1'b1, 7'd0);
      send_word(CMD_SPARE_LO, '1, '1, '1, 1'b1, 7'd127);
      send_word(CMD_SPARE_HI, '0, '0, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_ADD, '0, '1, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_ADD, 64'h2, 64'h6, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_TAKE, '0, '0, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_START, '0, '0, '0, 1'b0, 7'd2);
   endtask

   task automatic test_table_full();
      logic [63:0] up;
      write_dimension(7'd64);
      for (int i = 0; i < sisc_pkg::MAX_INTERVALS + 3; i++) begin
         up = rand64();
         send_word(sisc_pkg::CMD_ADD, up & rand64(), up, '0, 1'b0, 7'd0);
      end
      send_word(sisc_pkg::CMD_COVER_SET, '0, '0, rand64(), 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_START, '0, '0, '0, 1'b1, 7'd1);
      send_word(sisc_pkg::CMD_TAKE, '0, '0, '0, 1'b1, 7'd0);
      send_word(sisc_pkg::CMD_ADD, 64'h0, 64'hFFFF, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_ADD, '0, '1, '0, 1'b0, 7'd0);
      send_word(sisc_pkg::CMD_TAKE, '0, '0, '0, 1'b1, 7'd0);
   endtask

   task automatic test_random_phase(logic [6:0] d, int n, bit quiet, int hold);
      int r, pick;
      logic [63:0] lo, up, cand;
      write_dimension(d);
      idle_on = !quiet;
      if (hold > 0) begin
         hold_len = hold;
         hold_seq++;
      end
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 28) begin
            if (dim > 12) up = rand64() | rand64();
            else up = ~(rand64() & rand64() & rand64());
            lo = up & rand64() & rand64() & rand64();
            if ($urandom_range(19) == 0) lo = rand64();
            if ($urandom_range(59) == 0) begin
               lo = '0;
               up = '1;
            end
            send_word(sisc_pkg::CMD_ADD, lo, up, rand64(), $urandom_range(1), 7'($urandom));
         end else if (r < 40) begin
            cand = rand64();
            if (ivl_count > 0 && $urandom_range(1)) begin
               pick = $urandom_range(ivl_count - 1);
               cand = ivl_lo[pick] | (ivl_up[pick] & rand64()) | (~coord_mask() & rand64());
            end
            send_word(sisc_pkg::CMD_COVER_SET, rand64(), rand64(), cand, $urandom_range(1),
                      7'($urandom));
         end else if (r < 50) begin
            up = rand64();
            lo = up & rand64();
            if (ivl_count > 0 && $urandom_range(1)) begin
               pick = $urandom_range(ivl_count - 1);
               lo = ivl_lo[pick] | (ivl_up[pick] & rand64() & rand64());
               up = lo | (ivl_up[pick] & rand64());
            end
            if ($urandom_range(7) == 0) lo = rand64();
            send_word(sisc_pkg::CMD_COVER_IVL, lo, up, rand64(), $urandom_range(1),
                      7'($urandom));
         end else if (r < 62) begin
            send_word(sisc_pkg::CMD_START, rand64(), rand64(), rand64(), $urandom_range(1),
                      $urandom_range(4) == 0 ? 7'($urandom) : 7'($urandom_range(0, dim + 1)));
         end else if (r < 97) begin
            send_word(sisc_pkg::CMD_TAKE, rand64(), rand64(), rand64(), $urandom_range(1),
                      7'($urandom));
         end else begin
            send_word(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), rand64(), rand64(),
                      rand64(), $urandom_range(1), 7'($urandom));
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic test_random_dimensions();
      test_random_phase(7'd5, 150, 1'b0, 400);
      test_random_phase(7'd1, 100, 1'b0, 0);
      test_random_phase(7'd64, 120, 1'b0, 0);
      test_random_phase(7'd0, 60, 1'b0, 0);
      test_random_phase(7'd3, 130, 1'b1, 0);
      test_random_phase(7'd8, 160, 1'b0, 0);
      test_random_phase(7'd127, 80, 1'b0, 0);
      test_random_phase(7'd6, 160, 1'b0, 0);
      test_random_phase(7'd2, 100, 1'b0, 0);
      test_random_phase(7'd7, 150, 1'b0, 0);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.cmd = sisc_pkg::CMD_ADD;
      req_ch.lower_mask = '0;
      req_ch.upper_mask = '0;
      req_ch.candidate_mask = '0;
      req_ch.stream_sel = 1'b0;
      req_ch.cardinality = '0;
      dim = sisc_pkg::MAX_DIM;
      clear_cover();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_commands();
      test_table_full();
      test_random_dimensions();
      drain();
      repeat (40) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("words never returned", pending_results.size(), 0);
      if (errors == 0) begin
         $display("subset_interval_cover_search_unit regression: pass");
      end else begin
         $display("subset_interval_cover_search_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #(12 * 20_000_000);
      $display("subset_interval_cover_search_unit regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
